[sv/bnm_pkg.sv]
// Package: shared constants, codes and types of the bus node message responder.
package bnm_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int ADDR_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [15:0] HEADER_BLOCK = 16'hFFFF;
    localparam logic [15:0] ADDR_RESET   = 16'd4000;
    localparam logic [15:0] BLOCK_BYTES  = 16'd6;

    localparam logic [7:0] CMD_INFO         = 8'd0;
    localparam logic [7:0] CMD_INFO_ACK     = 8'd1;
    localparam logic [7:0] CMD_MEM_GET      = 8'd2;
    localparam logic [7:0] CMD_MEM_GET_ACK  = 8'd3;
    localparam logic [7:0] CMD_MEM_SET      = 8'd4;
    localparam logic [7:0] CMD_MEM_SET_ACK  = 8'd5;
    localparam logic [7:0] CMD_ADDR_SET     = 8'd6;
    localparam logic [7:0] CMD_ADDR_SET_ACK = 8'd7;
    localparam logic [7:0] CMD_MASTER_ACK   = 8'd9;

    localparam logic [3:0] LEN_FULL  = 4'd8;
    localparam logic [3:0] LEN_INFO  = 4'd4;
    localparam logic [3:0] LEN_SHORT = 4'd2;

    typedef enum logic [1:0] {
        ACT_REPLY   = 2'd0,
        ACT_DELIVER = 2'd1,
        ACT_FORWARD = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FWD
    } t_state;

    typedef struct packed {
        logic        is_message;
        logic [15:0] dest_address;
        logic [15:0] source_address;
        logic [7:0]  command;
        logic [15:0] first_word;
        logic [47:0] payload;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [15:0] reply_dest;
        logic [15:0] reply_source;
        logic [7:0]  reply_command;
        logic [15:0] reply_first_word;
        logic [47:0] reply_payload;
        logic [3:0]  reply_length;
        logic        memory_complete;
        logic        block_error;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fwd;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] n_res;
    } t_dp_status;

endpackage

[sv/bnm_if.sv]
// Interfaces: input item channel and result item channel.
interface bnm_in_if;
    logic        valid;
    logic        ready;
    logic        is_message;
    logic [15:0] dest_address;
    logic [15:0] source_address;
    logic [7:0]  command;
    logic [15:0] first_word;
    logic [47:0] payload;

    modport source (output valid, is_message, dest_address, source_address, command,
                    first_word, payload, input ready);
    modport sink (input valid, is_message, dest_address, source_address, command,
                  first_word, payload, output ready);
endinterface

interface bnm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] reply_dest;
    logic [15:0] reply_source;
    logic [7:0]  reply_command;
    logic [15:0] reply_first_word;
    logic [47:0] reply_payload;
    logic [3:0]  reply_length;
    logic        memory_complete;
    logic        block_error;
    logic        last;

    modport source (output valid, action, reply_dest, reply_source, reply_command,
                    reply_first_word, reply_payload, reply_length, memory_complete,
                    block_error, last, input ready);
    modport sink (input valid, action, reply_dest, reply_source, reply_command,
                  reply_first_word, reply_payload, reply_length, memory_complete,
                  block_error, last, output ready);
endinterface

[sv/bnm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bnm_ctrl.sv]
// Controller: sequences capture, execute and second-result phases and the output handshake.
module bnm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  bnm_pkg::t_dp_status i_status,
    output bnm_pkg::t_dp_cmd    o_cmd
);

    bnm_pkg::t_state r_state;
    bnm_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_can_load;
    logic            w_load;

    assign w_can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bnm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bnm_pkg::S_EXEC;
                end
            end
            bnm_pkg::S_EXEC: begin
                if (i_status.n_res == 2'd0) begin
                    n_state = bnm_pkg::S_IDLE;
                end else if (w_can_load) begin
                    n_state = (i_status.n_res == 2'd2) ? bnm_pkg::S_FWD : bnm_pkg::S_IDLE;
                end
            end
            bnm_pkg::S_FWD: begin
                if (w_can_load) begin
                    n_state = bnm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bnm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            bnm_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            bnm_pkg::S_EXEC: begin
                if (i_status.n_res == 2'd0) begin
                    o_cmd.exec = 1'b1;
                end else if (w_can_load) begin
                    o_cmd.exec = 1'b1;
                    w_load     = 1'b1;
                end
            end
            bnm_pkg::S_FWD: begin
                if (w_can_load) begin
                    o_cmd.fwd = 1'b1;
                    w_load    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || w_load;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bnm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[sv/bnm_dp.sv]
// Datapath: node state, block store, message decode and result register.
module bnm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bnm_pkg::t_dp_cmd    i_cmd,
    output bnm_pkg::t_dp_status o_status,
    input  bnm_pkg::t_in_item   i_in_item,
    output bnm_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);

    bnm_pkg::t_in_item             r_in;
    bnm_pkg::t_out_item            r_out;
    logic [15:0]                   r_node_addr;
    logic [bnm_pkg::CNT_W-1:0]     r_blk_cnt;
    logic [15:0]                   r_dev_type;

    logic [47:0]                   w_rdata;
    logic [15:0]                   w_blk;
    logic                          w_to_node;
    logic                          w_is_hdr;
    logic                          w_in_range;
    logic                          w_done;
    logic [15:0]                   w_new_cnt16;
    logic                          w_cnt_sat;
    logic [bnm_pkg::CNT_W-1:0]     w_new_cnt;
    logic [15:0]                   w_info_size;
    bnm_pkg::t_out_item            w_fwd;
    bnm_pkg::t_out_item            w_res0;
    logic [1:0]                    w_n_res;
    logic                          w_mem_we;
    logic                          w_cnt_we;
    logic                          w_addr_we;

    bnm_ram #(
        .WIDTH (48),
        .DEPTH (bnm_pkg::MAX_BLOCKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && w_mem_we),
        .i_waddr (r_in.first_word[bnm_pkg::ADDR_W-1:0]),
        .i_wdata (r_in.payload),
        .i_re    (i_cmd.capture),
        .i_raddr (i_in_item.first_word[bnm_pkg::ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_blk       = r_in.first_word;
    assign w_to_node   = r_in.is_message && (r_in.dest_address == r_node_addr);
    assign w_is_hdr    = (w_blk == bnm_pkg::HEADER_BLOCK);
    assign w_in_range  = (w_blk < 16'(r_blk_cnt)) && (w_blk < 16'(bnm_pkg::MAX_BLOCKS));
    assign w_done      = ((17'(w_blk) + 17'd1) >= 17'(r_blk_cnt));
    assign w_new_cnt16 = r_in.payload[47:32];
    assign w_cnt_sat   = (w_new_cnt16 > 16'(bnm_pkg::MAX_BLOCKS));
    assign w_new_cnt   = w_cnt_sat ? bnm_pkg::CNT_W'(bnm_pkg::MAX_BLOCKS)
                                   : w_new_cnt16[bnm_pkg::CNT_W-1:0];
    assign w_info_size = 16'(r_blk_cnt) * bnm_pkg::BLOCK_BYTES;

    always_comb begin
        w_fwd.action           = bnm_pkg::ACT_FORWARD;
        w_fwd.reply_dest       = r_in.dest_address;
        w_fwd.reply_source     = r_in.source_address;
        w_fwd.reply_command    = r_in.command;
        w_fwd.reply_first_word = r_in.first_word;
        w_fwd.reply_payload    = r_in.payload;
        w_fwd.reply_length     = bnm_pkg::LEN_FULL;
        w_fwd.memory_complete  = 1'b0;
        w_fwd.block_error      = 1'b0;
        w_fwd.last             = 1'b1;
    end

    always_comb begin
        w_res0    = w_fwd;
        w_n_res   = 2'd1;
        w_mem_we  = 1'b0;
        w_cnt_we  = 1'b0;
        w_addr_we = 1'b0;
        if (w_to_node) begin
            w_res0.action       = bnm_pkg::ACT_REPLY;
            w_res0.reply_dest   = r_in.source_address;
            w_res0.reply_source = r_node_addr;
            if ((r_in.dest_address == 16'd0) && (r_in.command != bnm_pkg::CMD_INFO)) begin
                w_n_res = 2'd0;
            end else begin
                case (r_in.command)
                    bnm_pkg::CMD_INFO: begin
                        w_res0.reply_command    = bnm_pkg::CMD_INFO_ACK;
                        w_res0.reply_first_word = r_dev_type;
                        w_res0.reply_payload    = {w_info_size, 32'd0};
                        w_res0.reply_length     = bnm_pkg::LEN_INFO;
                    end
                    bnm_pkg::CMD_MEM_GET: begin
                        w_res0.reply_command = bnm_pkg::CMD_MEM_GET_ACK;
                        if (w_is_hdr) begin
                            w_res0.reply_payload = {16'(r_blk_cnt), 32'd0};
                            w_res0.reply_length  = bnm_pkg::LEN_INFO;
                        end else if (w_in_range) begin
                            w_res0.reply_payload = w_rdata;
                        end else begin
                            w_res0.reply_payload = '0;
                            w_res0.block_error   = 1'b1;
                        end
                    end
                    bnm_pkg::CMD_MEM_SET: begin
                        w_res0.reply_command = bnm_pkg::CMD_MEM_SET_ACK;
                        w_res0.reply_payload = '0;
                        w_res0.reply_length  = bnm_pkg::LEN_SHORT;
                        if (w_is_hdr) begin
                            w_cnt_we           = 1'b1;
                            w_res0.block_error = w_cnt_sat;
                        end else if (w_in_range) begin
                            w_mem_we               = 1'b1;
                            w_res0.memory_complete = w_done;
                        end else begin
                            w_res0.block_error = 1'b1;
                        end
                    end
                    bnm_pkg::CMD_ADDR_SET: begin
                        w_addr_we            = 1'b1;
                        w_res0.reply_command = bnm_pkg::CMD_ADDR_SET_ACK;
                        w_res0.reply_payload = '0;
                        w_res0.reply_length  = bnm_pkg::LEN_SHORT;
                    end
                    bnm_pkg::CMD_INFO_ACK, bnm_pkg::CMD_MEM_GET_ACK,
                    bnm_pkg::CMD_MEM_SET_ACK, bnm_pkg::CMD_ADDR_SET_ACK,
                    bnm_pkg::CMD_MASTER_ACK: begin
                        w_n_res = 2'd0;
                    end
                    default: begin
                        w_res0        = w_fwd;
                        w_res0.action = bnm_pkg::ACT_DELIVER;
                    end
                endcase
            end
        end else if (r_in.is_message && (r_in.dest_address == 16'd0)
                     && (r_in.source_address != r_node_addr)
                     && (r_in.command == bnm_pkg::CMD_INFO)) begin
            w_n_res                 = 2'd2;
            w_res0.action           = bnm_pkg::ACT_REPLY;
            w_res0.reply_dest       = r_in.source_address;
            w_res0.reply_source     = r_node_addr;
            w_res0.reply_command    = bnm_pkg::CMD_INFO_ACK;
            w_res0.reply_first_word = r_dev_type;
            w_res0.reply_payload    = {w_info_size, 32'd0};
            w_res0.reply_length     = bnm_pkg::LEN_INFO;
            w_res0.last             = 1'b0;
        end
    end

    assign o_status.n_res = w_n_res;
    assign o_out_item     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr <= bnm_pkg::ADDR_RESET;
            r_blk_cnt   <= '0;
            r_dev_type  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dev_type <= i_cfg_wdata;
            end
            if (i_cmd.exec && w_cnt_we) begin
                r_blk_cnt <= w_new_cnt;
            end
            if (i_cmd.exec && w_addr_we) begin
                r_node_addr <= r_in.first_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_item;
        end
        if (i_cmd.exec && (w_n_res != 2'd0)) begin
            r_out <= w_res0;
        end else if (i_cmd.fwd) begin
            r_out <= w_fwd;
        end
    end

endmodule

[sv/bus_node_message_responder.sv]
// Top level: node-side responder of the addressed message bus.
//
//   channel  | dir | handshake        | beat
//   i_in     | in  | valid / ready    | one bus item
//   o_out    | out | valid / ready    | one result item, last marks the final one
//   i_cfg_*  | in  | write enable     | device type code
//
// An item passes through capture with block store read, then execute, which loads
// the result register. A broadcast info request adds a forward state for its second beat.
// The registered block store read is why capture and execute are separate states.
// Reset is synchronous, active low; node address returns to 4000, block count to zero.
// A full result register holds an item with a result in execute; input ready stays low until it drains.
module bus_node_message_responder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bnm_in_if.sink         i_in,
    bnm_out_if.source      o_out,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata
);

    bnm_pkg::t_dp_cmd    w_cmd;
    bnm_pkg::t_dp_status w_status;
    bnm_pkg::t_in_item   w_in_item;
    bnm_pkg::t_out_item  w_out_item;

    assign w_in_item.is_message     = i_in.is_message;
    assign w_in_item.dest_address   = i_in.dest_address;
    assign w_in_item.source_address = i_in.source_address;
    assign w_in_item.command        = i_in.command;
    assign w_in_item.first_word     = i_in.first_word;
    assign w_in_item.payload        = i_in.payload;

    bnm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bnm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (w_in_item),
        .o_out_item  (w_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    assign o_out.action           = w_out_item.action;
    assign o_out.reply_dest       = w_out_item.reply_dest;
    assign o_out.reply_source     = w_out_item.reply_source;
    assign o_out.reply_command    = w_out_item.reply_command;
    assign o_out.reply_first_word = w_out_item.reply_first_word;
    assign o_out.reply_payload    = w_out_item.reply_payload;
    assign o_out.reply_length     = w_out_item.reply_length;
    assign o_out.memory_complete  = w_out_item.memory_complete;
    assign o_out.block_error      = w_out_item.block_error;
    assign o_out.last             = w_out_item.last;

endmodule

[tb/tb_bus_node_message_responder.sv]
`timescale 1ns / 1ps
// Testbench: self-checking regression of the bus node message responder.
module tb_bus_node_message_responder;

    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    bnm_in_if  in_bus ();
    bnm_out_if out_bus ();

    bus_node_message_responder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [15:0]        dev_type_q;
    logic [15:0]        node_addr_q;
    int                 blk_count_q;
    logic [47:0]        blocks_q [bnm_pkg::MAX_BLOCKS];
    bit                 written_q [bnm_pkg::MAX_BLOCKS];
    bnm_pkg::t_out_item pending_results [$];

    int failures;
    int answered_items;
    int send_idle_pct;
    int stall_pct;
    int hold_off_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bnm_pkg::t_in_item bus_item(logic is_msg, logic [15:0] dst,
                                                   logic [15:0] src, logic [7:0] cmd,
                                                   logic [15:0] fw, logic [47:0] pl);
        return {is_msg, dst, src, cmd, fw, pl};
    endfunction

    function automatic logic [47:0] random_payload();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic void queue_result(bnm_pkg::t_action act, logic [15:0] dst,
                                         logic [15:0] src, logic [7:0] cmd,
                                         logic [15:0] fw, logic [47:0] pl,
                                         logic [3:0] len, logic done, logic err, logic fin);
        pending_results.push_back({act, dst, src, cmd, fw, pl, len, done, err, fin});
    endfunction

    function automatic int respond_to_item(bnm_pkg::t_in_item it);
        logic [15:0] blk;
        logic [15:0] info_size;
        logic [15:0] old_addr;
        int          n;
        logic        done;
        logic        err;
        blk = it.first_word;
        info_size = 16'(blk_count_q * 6);
        done = 1'b0;
        err = 1'b0;
        if (it.is_message && it.dest_address == node_addr_q) begin
            if (it.dest_address == 16'd0 && it.command != bnm_pkg::CMD_INFO) return 0;
            case (it.command)
                bnm_pkg::CMD_INFO: begin
                    queue_result(bnm_pkg::ACT_REPLY, it.source_address, node_addr_q,
                                 bnm_pkg::CMD_INFO_ACK, dev_type_q, {info_size, 32'd0},
                                 bnm_pkg::LEN_INFO, 1'b0, 1'b0, 1'b1);
                end
                bnm_pkg::CMD_MEM_GET: begin
                    if (blk == bnm_pkg::HEADER_BLOCK) begin
                        queue_result(bnm_pkg::ACT_REPLY, it.source_address, node_addr_q,
                                     bnm_pkg::CMD_MEM_GET_ACK, blk,
                                     {16'(blk_count_q), 32'd0}, bnm_pkg::LEN_INFO,
                                     1'b0, 1'b0, 1'b1);
                    end else if (int'(blk) < blk_count_q &&
                                 int'(blk) < bnm_pkg::MAX_BLOCKS) begin
                        queue_result(bnm_pkg::ACT_REPLY, it.source_address, node_addr_q,
                                     bnm_pkg::CMD_MEM_GET_ACK, blk, blocks_q[blk],
                                     bnm_pkg::LEN_FULL, 1'b0, 1'b0, 1'b1);
                    end else begin
                        queue_result(bnm_pkg::ACT_REPLY, it.source_address, node_addr_q,
                                     bnm_pkg::CMD_MEM_GET_ACK, blk, 48'd0,
                                     bnm_pkg::LEN_FULL, 1'b0, 1'b1, 1'b1);
                    end
                end
                bnm_pkg::CMD_MEM_SET: begin
                    if (blk == bnm_pkg::HEADER_BLOCK) begin
                        n = int'(it.payload[47:32]);
                        if (n > bnm_pkg::MAX_BLOCKS) begin
                            n = bnm_pkg::MAX_BLOCKS;
                            err = 1'b1;
                        end
                        blk_count_q = n;
                    end else if (int'(blk) < blk_count_q &&
                                 int'(blk) < bnm_pkg::MAX_BLOCKS) begin
                        blocks_q[blk] = it.payload;
                        written_q[blk] = 1'b1;
                        done = (int'(blk) + 1 >= blk_count_q);
                    end else begin
                        err = 1'b1;
                    end
                    queue_result(bnm_pkg::ACT_REPLY, it.source_address, node_addr_q,
                                 bnm_pkg::CMD_MEM_SET_ACK, blk, 48'd0,
                                 bnm_pkg::LEN_SHORT, done, err, 1'b1);
                end
                bnm_pkg::CMD_ADDR_SET: begin
                    old_addr = node_addr_q;
                    node_addr_q = it.first_word;
                    queue_result(bnm_pkg::ACT_REPLY, it.source_address, old_addr,
                                 bnm_pkg::CMD_ADDR_SET_ACK, it.first_word, 48'd0,
                                 bnm_pkg::LEN_SHORT, 1'b0, 1'b0, 1'b1);
                end
                bnm_pkg::CMD_INFO_ACK, bnm_pkg::CMD_MEM_GET_ACK, bnm_pkg::CMD_MEM_SET_ACK,
                bnm_pkg::CMD_ADDR_SET_ACK, bnm_pkg::CMD_MASTER_ACK: return 0;
                default: begin
                    queue_result(bnm_pkg::ACT_DELIVER, it.dest_address, it.source_address,
                                 it.command, it.first_word, it.payload,
                                 bnm_pkg::LEN_FULL, 1'b0, 1'b0, 1'b1);
                end
            endcase
            return 1;
        end
        if (it.is_message && it.dest_address == 16'd0 && it.source_address != node_addr_q &&
            it.command == bnm_pkg::CMD_INFO) begin
            queue_result(bnm_pkg::ACT_REPLY, it.source_address, node_addr_q,
                         bnm_pkg::CMD_INFO_ACK, dev_type_q, {info_size, 32'd0},
                         bnm_pkg::LEN_INFO, 1'b0, 1'b0, 1'b0);
            queue_result(bnm_pkg::ACT_FORWARD, it.dest_address, it.source_address,
                         it.command, it.first_word, it.payload, bnm_pkg::LEN_FULL,
                         1'b0, 1'b0, 1'b1);
            return 2;
        end
        queue_result(bnm_pkg::ACT_FORWARD, it.dest_address, it.source_address, it.command,
                     it.first_word, it.payload, bnm_pkg::LEN_FULL, 1'b0, 1'b0, 1'b1);
        return 1;
    endfunction

    function automatic bnm_pkg::t_in_item random_item();
        bnm_pkg::t_in_item it;
        int                pick;
        it.is_message = ($urandom_range(99) < 90);
        pick = $urandom_range(99);
        it.dest_address = (pick < 60) ? node_addr_q : (pick < 75) ? 16'd0 : 16'($urandom);
        it.source_address = ($urandom_range(9) == 0) ? node_addr_q : 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 20) it.command = bnm_pkg::CMD_INFO;
        else if (pick < 45) it.command = bnm_pkg::CMD_MEM_GET;
        else if (pick < 70) it.command = bnm_pkg::CMD_MEM_SET;
        else if (pick < 75) it.command = bnm_pkg::CMD_ADDR_SET;
        else if (pick < 85) it.command = 8'($urandom_range(0, 4) * 2 + 1);
        else it.command = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 10) it.first_word = bnm_pkg::HEADER_BLOCK;
        else if (pick < 80) it.first_word = 16'($urandom_range(0, blk_count_q + 2));
        else it.first_word = 16'($urandom);
        it.payload = random_payload();
        if (it.command == bnm_pkg::CMD_MEM_SET && it.first_word == bnm_pkg::HEADER_BLOCK) begin
            pick = $urandom_range(99);
            if (pick < 70) it.payload[47:32] = 16'($urandom_range(0, 16));
            else if (pick < 80) it.payload[47:32] = 16'(bnm_pkg::MAX_BLOCKS);
            else if (pick < 90) it.payload[47:32] = 16'(bnm_pkg::MAX_BLOCKS + 1);
        end
        if (it.command == bnm_pkg::CMD_ADDR_SET &&
            ($urandom_range(1) == 0 || it.first_word == 16'd0))
            it.first_word = bnm_pkg::ADDR_RESET;
        return it;
    endfunction

    task automatic send_item(bnm_pkg::t_in_item it);
        // turn a read of a never-written block into a write of it
        if (it.is_message && it.dest_address == node_addr_q && it.dest_address != 16'd0 &&
            it.command == bnm_pkg::CMD_MEM_GET && int'(it.first_word) < blk_count_q &&
            int'(it.first_word) < bnm_pkg::MAX_BLOCKS && !written_q[it.first_word])
            it.command = bnm_pkg::CMD_MEM_SET;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid          <= 1'b1;
        in_bus.is_message     <= it.is_message;
        in_bus.dest_address   <= it.dest_address;
        in_bus.source_address <= it.source_address;
        in_bus.command        <= it.command;
        in_bus.first_word     <= it.first_word;
        in_bus.payload        <= it.payload;
        do @(posedge i_clk); while (!in_bus.ready);
        if (respond_to_item(it) > 0) answered_items++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_device_type(logic [15:0] value);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        dev_type_q = value;
    endtask

    task automatic test_forwarding();
        send_item(bus_item(1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 48'h0));
        send_item(bus_item(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
    endtask

    task automatic test_info_requests();
        write_device_type(16'hFFFF);
        send_item(bus_item(1'b1, node_addr_q, 16'h1234, bnm_pkg::CMD_INFO, 16'h0,
                           random_payload()));
        send_item(bus_item(1'b1, 16'h0000, 16'hABCD, bnm_pkg::CMD_INFO, 16'h5A5A,
                           random_payload()));
        send_item(bus_item(1'b1, 16'h0000, node_addr_q, bnm_pkg::CMD_INFO, 16'h0,
                           random_payload()));
        send_item(bus_item(1'b1, 16'h0000, 16'hABCD, bnm_pkg::CMD_MEM_SET, 16'h0,
                           random_payload()));
    endtask

    task automatic test_memory_access();
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_GET,
                           bnm_pkg::HEADER_BLOCK, 48'h0));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_GET, 16'h0000,
                           48'h0));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_SET, 16'h0000,
                           48'h1));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_SET,
                           bnm_pkg::HEADER_BLOCK, {16'd2, 32'hFFFF_FFFF}));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_SET, 16'h0000,
                           48'h0));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_SET, 16'h0001,
                           48'hFFFF_FFFF_FFFF));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_GET, 16'h0001,
                           48'h0));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_GET, 16'h0002,
                           48'h0));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_SET,
                           bnm_pkg::HEADER_BLOCK, {16'(bnm_pkg::MAX_BLOCKS + 1), 32'h0}));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_SET,
                           16'(bnm_pkg::MAX_BLOCKS - 1), 48'hFFFF_FFFF_FFFF));
        send_item(bus_item(1'b1, node_addr_q, 16'h0011, bnm_pkg::CMD_MEM_GET,
                           16'(bnm_pkg::MAX_BLOCKS - 1), 48'h0));
    endtask

    task automatic test_answers_and_delivery();
        logic [7:0] answers [5];
        answers = '{bnm_pkg::CMD_INFO_ACK, bnm_pkg::CMD_MEM_GET_ACK, bnm_pkg::CMD_MEM_SET_ACK,
                    bnm_pkg::CMD_ADDR_SET_ACK, bnm_pkg::CMD_MASTER_ACK};
        foreach (answers[k])
            send_item(bus_item(1'b1, node_addr_q, 16'h0077, answers[k], 16'h0,
                               random_payload()));
        send_item(bus_item(1'b1, node_addr_q, 16'h0077, 8'd8, 16'hFFFF, random_payload()));
        send_item(bus_item(1'b1, node_addr_q, 16'h0077, 8'hFF, 16'h0000, random_payload()));
    endtask

    task automatic test_address_change();
        send_item(bus_item(1'b1, node_addr_q, 16'h0099, bnm_pkg::CMD_ADDR_SET, 16'hFFFF,
                           48'h0));
        send_item(bus_item(1'b1, bnm_pkg::ADDR_RESET, 16'h0099, bnm_pkg::CMD_INFO, 16'h0,
                           48'h0));
        send_item(bus_item(1'b1, node_addr_q, 16'h0099, bnm_pkg::CMD_ADDR_SET,
                           bnm_pkg::ADDR_RESET, 48'h0));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_left = 60;
        repeat (16) send_item(random_item());
        wait_results_drained();
        repeat (6) send_item(random_item());
    endtask

    task automatic run_memory_session();
        int          n;
        logic [15:0] peer;
        n = $urandom_range(1, 12);
        peer = 16'($urandom);
        send_item(bus_item(1'b1, node_addr_q, peer, bnm_pkg::CMD_MEM_SET,
                           bnm_pkg::HEADER_BLOCK, {16'(n), 32'($urandom)}));
        for (int b = 0; b < n; b++)
            send_item(bus_item(1'b1, node_addr_q, peer, bnm_pkg::CMD_MEM_SET, 16'(b),
                               random_payload()));
        repeat ($urandom_range(1, 4))
            send_item(bus_item(1'b1, node_addr_q, peer, bnm_pkg::CMD_MEM_GET,
                               16'($urandom_range(0, n + 1)), random_payload()));
    endtask

    task automatic test_random_traffic(int idle_pct, int stall, logic [15:0] dtype, int target);
        int base;
        write_device_type(dtype);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        base = answered_items;
        while (answered_items - base < target) begin
            if ($urandom_range(99) < 30) run_memory_session();
            else send_item(random_item());
        end
    endtask

    task automatic test_zero_address();
        send_idle_pct = 0;
        stall_pct = 0;
        send_item(bus_item(1'b1, node_addr_q, 16'h0042, bnm_pkg::CMD_ADDR_SET, 16'h0000,
                           48'h0));
        send_item(bus_item(1'b1, 16'h0000, 16'h0042, bnm_pkg::CMD_MEM_GET, 16'h0000,
                           48'h0));
        send_item(bus_item(1'b1, 16'h0000, 16'h0042, bnm_pkg::CMD_MEM_SET,
                           bnm_pkg::HEADER_BLOCK, {16'd4, 32'h0}));
        send_item(bus_item(1'b1, 16'h0000, 16'h0042, bnm_pkg::CMD_INFO, 16'h0,
                           random_payload()));
        send_item(bus_item(1'b1, 16'h0000, 16'h0000, bnm_pkg::CMD_INFO, 16'h0,
                           random_payload()));
        send_item(bus_item(1'b1, 16'h0101, 16'h0042, bnm_pkg::CMD_MEM_GET, 16'h0,
                           random_payload()));
    endtask

    function automatic string describe(bnm_pkg::t_out_item r);
        return $sformatf({"act=%0d dst=%h src=%h cmd=%h fw=%h pl=%h len=%0d ",
                          "done=%b err=%b last=%b"},
                         r.action, r.reply_dest, r.reply_source, r.reply_command,
                         r.reply_first_word, r.reply_payload, r.reply_length,
                         r.memory_complete, r.block_error, r.last);
    endfunction

    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        bnm_pkg::t_out_item got;
        bnm_pkg::t_out_item want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = {bnm_pkg::t_action'(out_bus.action), out_bus.reply_dest,
                   out_bus.reply_source, out_bus.reply_command, out_bus.reply_first_word,
                   out_bus.reply_payload, out_bus.reply_length, out_bus.memory_complete,
                   out_bus.block_error, out_bus.last};
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result beat: %s", describe(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 describe(want), describe(got));
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 16'h0;
        in_bus.valid = 1'b0;
        in_bus.is_message = 1'b0;
        in_bus.dest_address = 16'h0;
        in_bus.source_address = 16'h0;
        in_bus.command = 8'h0;
        in_bus.first_word = 16'h0;
        in_bus.payload = 48'h0;
        failures = 0;
        answered_items = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_left = 0;
        dev_type_q = 16'h0;
        node_addr_q = bnm_pkg::ADDR_RESET;
        blk_count_q = 0;
        foreach (written_q[k]) begin
            written_q[k] = 1'b0;
            blocks_q[k] = 48'h0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_forwarding();
        test_info_requests();
        test_memory_access();
        test_answers_and_delivery();
        test_address_change();
        test_backpressure();
        test_random_traffic(0, 0, 16'h0000, 85);
        test_random_traffic(74, 0, 16'hFFFF, 85);
        test_random_traffic(0, 74, 16'($urandom), 85);
        test_random_traffic(20, 20, 16'($urandom), 85);
        test_zero_address();
        wait_results_drained();

        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
